FILE: sv/crc32_pkg.sv
// shared types, constants and the byte update function for the crc-32 stream block
`timescale 1ns / 1ps

package crc32_pkg;

    localparam int          CRC_W        = 32;
    localparam int          BYTE_W       = 8;
    localparam int          CFG_IDX_W    = 1;
    localparam int          CFG_DATA_W   = 32;

    localparam logic [CRC_W-1:0]  CRC_POLY       = 32'hEDB8_8320;
    localparam logic [CRC_W-1:0]  CRC_RESET      = 32'hFFFF_FFFF;
    localparam logic [BYTE_W-1:0] SLASH_BYTE     = 8'h2F;
    localparam logic [BYTE_W-1:0] BACKSLASH_BYTE = 8'h5C;

    localparam logic [CFG_IDX_W-1:0] REG_START_VALUE     = 1'd0;
    localparam logic [CFG_IDX_W-1:0] REG_SKIP_SEPARATORS = 1'd1;

    typedef struct packed {
        logic [CRC_W-1:0] start_value;
        logic             skip_separators;
    } t_cfg;

    typedef struct packed {
        logic [BYTE_W-1:0] data_byte;
        logic              has_byte;
        logic              first_item;
        logic              last_item;
    } t_item;

    // one reflected crc byte step, eight shift/xor bit steps
    function automatic logic [CRC_W-1:0] crc_byte_step(
        input logic [CRC_W-1:0]  crc_in,
        input logic [BYTE_W-1:0] data
    );
        logic [CRC_W-1:0] crc;
        crc = crc_in ^ {{(CRC_W-BYTE_W){1'b0}}, data};
        for (int k = 0; k < BYTE_W; k++) begin
            if (crc[0]) begin
                crc = (crc >> 1) ^ CRC_POLY;
            end else begin
                crc = crc >> 1;
            end
        end
        return crc;
    endfunction

endpackage

FILE: sv/crc32_byte_stream.sv
// top level: reflected crc-32 over a byte stream with input and result registers
`timescale 1ns / 1ps

// Reflected CRC-32 (polynomial 0xEDB88320) over a message fed one byte per
// transfer. A transfer with first_item reloads the running register with the
// inverse of start_value, a transfer with has_byte folds its byte in (slash and
// backslash are passed over when skip_separators is set), and a transfer with
// last_item produces one result transfer carrying the inverted register. The
// block takes one transfer per cycle: a transfer lands in the input register,
// the byte update is xor logic into the running register, and a final crc is
// held in the result register until taken. Input stalls only when a last-item
// transfer waits for a result register that is full and stalled. Write
// configuration only while idle.
module crc32_byte_stream (
    input  logic                             i_clk,
    input  logic                             i_rst_n,
    // input channel
    input  logic                             i_in_valid,
    output logic                             o_in_stall,
    input  logic [crc32_pkg::BYTE_W-1:0]     i_data_byte,
    input  logic                             i_has_byte,
    input  logic                             i_first_item,
    input  logic                             i_last_item,
    // result channel
    output logic                             o_out_valid,
    input  logic                             i_out_stall,
    output logic [crc32_pkg::CRC_W-1:0]      o_crc_value,
    // configuration write port
    input  logic                             i_cfg_we,
    input  logic [crc32_pkg::CFG_IDX_W-1:0]  i_cfg_index,
    input  logic [crc32_pkg::CFG_DATA_W-1:0] i_cfg_data
);
    import crc32_pkg::*;

    t_cfg             w_cfg;
    t_item            r_s1_item;
    logic             r_s1_valid;
    logic             w_s1_fire;
    logic             w_out_free;
    logic [CRC_W-1:0] w_crc_next;
    logic             r_out_valid;
    logic [CRC_W-1:0] r_crc_value;

    crc32_cfg u_cfg (
        .i_clk       (i_clk),
        .i_rst_n     (i_rst_n),
        .i_cfg_we    (i_cfg_we),
        .i_cfg_index (i_cfg_index),
        .i_cfg_data  (i_cfg_data),
        .o_cfg       (w_cfg)
    );

    // result register is free when empty or being taken this cycle
    assign w_out_free = !r_out_valid || !i_out_stall;

    // the staged item moves on unless it needs the result register and cannot get it
    assign w_s1_fire  = r_s1_valid && (!r_s1_item.last_item || w_out_free);

    // input register refills whenever it is empty or its item moves on
    assign o_in_stall = r_s1_valid && !w_s1_fire;

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_s1_valid <= 1'b0;
        end else if (!o_in_stall) begin
            r_s1_valid <= i_in_valid;
        end
    end

    // payload, no reset
    always_ff @(posedge i_clk) begin
        if (i_in_valid && !o_in_stall) begin
            r_s1_item.data_byte  <= i_data_byte;
            r_s1_item.has_byte   <= i_has_byte;
            r_s1_item.first_item <= i_first_item;
            r_s1_item.last_item  <= i_last_item;
        end
    end

    crc32_core u_core (
        .i_clk      (i_clk),
        .i_rst_n    (i_rst_n),
        .i_fire     (w_s1_fire),
        .i_item     (r_s1_item),
        .i_cfg      (w_cfg),
        .o_crc_next (w_crc_next)
    );

    // result register: loads the inverted crc at the end of a message
    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_out_valid <= 1'b0;
        end else if (w_s1_fire && r_s1_item.last_item) begin
            r_out_valid <= 1'b1;
        end else if (!i_out_stall) begin
            r_out_valid <= 1'b0;
        end
    end

    always_ff @(posedge i_clk) begin
        if (w_s1_fire && r_s1_item.last_item) begin
            r_crc_value <= ~w_crc_next;
        end
    end

    assign o_out_valid = r_out_valid;
    assign o_crc_value = r_crc_value;

    // a finished crc never overwrites one still waiting to be taken
    a_no_overwrite: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        (w_s1_fire && r_s1_item.last_item) |-> !(r_out_valid && i_out_stall))
        else $error("result register overwritten while stalled");

    // an accepted input transfer is held in the input register next cycle
    a_in_captured: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        (i_in_valid && !o_in_stall) |=> r_s1_valid)
        else $error("accepted input transfer lost");

    // a stalled result is kept while non-final items keep flowing
    a_out_kept: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        (r_out_valid && i_out_stall && !(w_s1_fire && r_s1_item.last_item))
        |=> (o_out_valid && $stable(r_crc_value)))
        else $error("stalled result dropped or changed");

endmodule

FILE: sv/crc32_cfg.sv
// configuration registers: start value and separator skip
`timescale 1ns / 1ps

module crc32_cfg (
    input  logic                             i_clk,
    input  logic                             i_rst_n,
    input  logic                             i_cfg_we,
    input  logic [crc32_pkg::CFG_IDX_W-1:0]  i_cfg_index,
    input  logic [crc32_pkg::CFG_DATA_W-1:0] i_cfg_data,
    output crc32_pkg::t_cfg                  o_cfg
);
    import crc32_pkg::*;

    t_cfg r_cfg;

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_cfg.start_value     <= '0;
            r_cfg.skip_separators <= 1'b0;
        end else if (i_cfg_we) begin
            case (i_cfg_index)
                REG_START_VALUE:     r_cfg.start_value     <= i_cfg_data[CRC_W-1:0];
                REG_SKIP_SEPARATORS: r_cfg.skip_separators <= i_cfg_data[0];
                default:             r_cfg <= r_cfg;
            endcase
        end
    end

    assign o_cfg = r_cfg;

endmodule

FILE: sv/crc32_core.sv
// running crc register and its combinational byte update
`timescale 1ns / 1ps

module crc32_core (
    input  logic                         i_clk,
    input  logic                         i_rst_n,
    input  logic                         i_fire,
    input  crc32_pkg::t_item             i_item,
    input  crc32_pkg::t_cfg              i_cfg,
    output logic [crc32_pkg::CRC_W-1:0]  o_crc_next
);
    import crc32_pkg::*;

    logic [CRC_W-1:0] r_crc;
    logic [CRC_W-1:0] n_crc;
    logic [CRC_W-1:0] w_base;
    logic             w_sep;

    always_comb begin
        w_base = i_item.first_item ? ~i_cfg.start_value : r_crc;
        w_sep  = (i_item.data_byte == SLASH_BYTE) || (i_item.data_byte == BACKSLASH_BYTE);
        if (i_item.has_byte && !(i_cfg.skip_separators && w_sep)) begin
            n_crc = crc_byte_step(w_base, i_item.data_byte);
        end else begin
            n_crc = w_base;
        end
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_crc <= CRC_RESET;
        end else if (i_fire) begin
            r_crc <= n_crc;
        end
    end

    assign o_crc_next = n_crc;

endmodule
